[design/mag_stripe_track_deframer_macros.svh]
// Assertion helpers shared by the deframer modules.
// Both expect clk and rst_n in the enclosing scope.
`ifndef MAG_STRIPE_TRACK_DEFRAMER_MACROS_SVH
`define MAG_STRIPE_TRACK_DEFRAMER_MACROS_SVH

`ifndef SYNTH
`define MSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MSD_ASSERT(lbl, prop, msg)
`define MSD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[design/msd_pkg.sv]
package msd_pkg;

    // request command codes
    localparam logic [1:0] CMD_CLOCK = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] ADDR_START = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_END   = 3'd4;

    localparam logic [4:0] START_SENTINEL_RST = 5'd11;
    localparam logic [3:0] END_SENTINEL_RST   = 4'd15;

    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage

[design/msd_if.sv]
interface msd_in_if;
    import msd_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic       data_line;
    logic       enable_line;

    modport source (output valid, command, data_line, enable_line, input ready);
    modport sink   (input valid, command, data_line, enable_line, output ready);
endinterface

interface msd_out_if;
    import msd_pkg::*;

    logic       valid;
    logic       ready;
    logic [3:0] character;
    logic       character_valid;
    logic       track_loaded;
    logic [5:0] stored_count;

    modport source (output valid, character, character_valid, track_loaded, stored_count,
                    input ready);
    modport sink   (input valid, character, character_valid, track_loaded, stored_count,
                    output ready);
endinterface

[design/mag_stripe_track_deframer.sv]
// Track-2 style magnetic stripe deframer. Each request on in_ch is one of: a card clock
// falling edge with the raw active-low data and card-present pin levels, a read of the
// next stored character, or a reset. Every request gives exactly one result on out_ch.
// A request is accepted, then in an execute step the framing state is updated and the
// character store is read or written through its registered port, and then the result
// is held until taken; no new request is accepted until the result is taken. The
// character store holds MAX_CHARS entries and is tracked by a fill count, so reset needs
// no clearing pass. Start and end sentinels are set at APB offsets 0 and 4.
module mag_stripe_track_deframer #(
    parameter int MAX_CHARS = 40
) (
    input  logic                          clk,
    input  logic                          rst_n,
    msd_in_if.sink                        in_ch,
    msd_out_if.source                     out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msd_pkg::APB_AW-1:0]    paddr,
    input  logic [msd_pkg::APB_DW-1:0]    pwdata,
    output logic [msd_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import msd_pkg::*;

    ctrl_cmd_t  cmd;
    logic [4:0] start_sentinel;
    logic [3:0] end_sentinel;

    msd_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start_sentinel (start_sentinel),
        .end_sentinel   (end_sentinel)
    );

    msd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    msd_dp #(
        .MAX_CHARS (MAX_CHARS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .command         (in_ch.command),
        .data_line       (in_ch.data_line),
        .enable_line     (in_ch.enable_line),
        .start_sentinel  (start_sentinel),
        .end_sentinel    (end_sentinel),
        .character       (out_ch.character),
        .character_valid (out_ch.character_valid),
        .track_loaded    (out_ch.track_loaded),
        .stored_count    (out_ch.stored_count)
    );

endmodule

[design/msd_regs.sv]
module msd_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msd_pkg::APB_AW-1:0]    paddr,
    input  logic [msd_pkg::APB_DW-1:0]    pwdata,
    output logic [msd_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output logic [4:0]                    start_sentinel,
    output logic [3:0]                    end_sentinel
);
    import msd_pkg::*;

    logic [4:0] start_reg;
    logic [3:0] end_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= START_SENTINEL_RST;
            end_reg   <= END_SENTINEL_RST;
        end
        else if (wr_en)
        begin
            if (paddr == ADDR_START)
                start_reg <= pwdata[4:0];
            if (paddr == ADDR_END)
                end_reg <= pwdata[3:0];
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_START: prdata = {{(APB_DW-5){1'b0}}, start_reg};
            ADDR_END:   prdata = {{(APB_DW-4){1'b0}}, end_reg};
            default:    prdata = '0;
        endcase
    end

    assign start_sentinel = start_reg;
    assign end_sentinel   = end_reg;

endmodule

[design/msd_ctrl.sv]
`include "mag_stripe_track_deframer_macros.svh"

module msd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output msd_pkg::ctrl_cmd_t cmd
);
    import msd_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_RESP} state_t;

    state_t state_reg;
    logic   in_ready_reg;
    logic   out_valid_reg;

    always_comb
    begin
        cmd.load = in_valid && in_ready_reg;
        cmd.exec = (state_reg == ST_EXEC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg    <= ST_EXEC;
                        in_ready_reg <= 1'b0;
                    end
                end
                ST_EXEC:
                begin
                    state_reg     <= ST_RESP;
                    out_valid_reg <= 1'b1;
                end
                ST_RESP:
                begin
                    if (out_ready)
                    begin
                        state_reg     <= ST_IDLE;
                        out_valid_reg <= 1'b0;
                        in_ready_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg     <= ST_IDLE;
                    in_ready_reg  <= 1'b1;
                    out_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

    `MSD_ASSERT(a_no_overlap, !(in_ready_reg && out_valid_reg), "ready and result valid together")
    `MSD_ASSERT_NEXT(a_load_exec, cmd.load, state_reg == ST_EXEC, "accepted request not executed")
    `MSD_ASSERT_NEXT(a_exec_resp, state_reg == ST_EXEC, out_valid_reg, "execute without result")

endmodule

[design/msd_dp.sv]
`include "mag_stripe_track_deframer_macros.svh"

module msd_dp #(
    parameter int MAX_CHARS = 40
) (
    input  logic               clk,
    input  logic               rst_n,
    input  msd_pkg::ctrl_cmd_t cmd,
    input  logic [1:0]         command,
    input  logic               data_line,
    input  logic               enable_line,
    input  logic [4:0]         start_sentinel,
    input  logic [3:0]         end_sentinel,
    output logic [3:0]         character,
    output logic               character_valid,
    output logic               track_loaded,
    output logic [5:0]         stored_count
);
    import msd_pkg::*;

    localparam int CW = $clog2(MAX_CHARS + 1);
    localparam int AW = $clog2(MAX_CHARS);

    // latched request
    logic [1:0]    item_cmd_reg;
    logic          item_data_reg;
    logic          item_en_reg;

    logic [4:0]    shift_reg,  shift_next;
    logic          found_reg,  found_next;
    logic [2:0]    bi_reg,     bi_next;
    logic [CW-1:0] total_reg,  total_next;
    logic [CW-1:0] rp_reg,     rp_next;
    logic          loaded_reg, loaded_next;
    logic [3:0]    last_reg,   last_next;
    logic          hit_reg,    hit_next;

    logic [3:0]    char_mem [MAX_CHARS];
    logic [3:0]    rd_reg;

    logic          bit_val;
    logic [4:0]    slide;
    logic          we;
    logic          re;
    logic          clear;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_cmd_reg  <= command;
            item_data_reg <= data_line;
            item_en_reg   <= enable_line;
        end
    end

    // pins are active low
    assign bit_val = ~item_data_reg;
    assign slide   = {bit_val, shift_reg[4:1]};

    always_comb
    begin
        shift_next  = shift_reg;
        found_next  = found_reg;
        bi_next     = bi_reg;
        total_next  = total_reg;
        rp_next     = rp_reg;
        loaded_next = loaded_reg;
        last_next   = last_reg;
        hit_next    = hit_reg;
        we          = 1'b0;
        re          = 1'b0;
        clear       = 1'b0;
        if (cmd.exec)
        begin
            hit_next = 1'b0;
            case (item_cmd_reg)
                CMD_CLOCK:
                begin
                    if (!item_en_reg && !loaded_reg)
                    begin
                        if (!found_reg)
                        begin
                            if (slide == start_sentinel)
                            begin
                                found_next = 1'b1;
                                shift_next = '0;
                            end
                            else
                                shift_next = slide;
                        end
                        else if (!bi_reg[2])
                        begin
                            shift_next[bi_reg[1:0]] = shift_reg[bi_reg[1:0]] | bit_val;
                            bi_next = bi_reg + 3'd1;
                        end
                        else
                        begin
                            // parity bit: store the character, drop it when full
                            shift_next = '0;
                            bi_next    = '0;
                            if (total_reg < CW'(MAX_CHARS))
                            begin
                                we         = 1'b1;
                                last_next  = shift_reg[3:0];
                                total_next = total_reg + CW'(1);
                            end
                            if ((total_next != '0) && (last_next == end_sentinel))
                                loaded_next = 1'b1;
                        end
                    end
                end
                CMD_READ:
                begin
                    if (loaded_reg && (rp_reg < total_reg))
                    begin
                        re       = 1'b1;
                        hit_next = 1'b1;
                        rp_next  = rp_reg + CW'(1);
                    end
                    else
                        clear = 1'b1;
                end
                CMD_RESET:
                    clear = 1'b1;
                default:
                    clear = 1'b0;
            endcase
            if (clear)
            begin
                shift_next  = '0;
                found_next  = 1'b0;
                bi_next     = '0;
                total_next  = '0;
                rp_next     = '0;
                loaded_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  <= '0;
            found_reg  <= 1'b0;
            bi_reg     <= '0;
            total_reg  <= '0;
            rp_reg     <= '0;
            loaded_reg <= 1'b0;
            last_reg   <= '0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            shift_reg  <= shift_next;
            found_reg  <= found_next;
            bi_reg     <= bi_next;
            total_reg  <= total_next;
            rp_reg     <= rp_next;
            loaded_reg <= loaded_next;
            last_reg   <= last_next;
            hit_reg    <= hit_next;
        end
    end

    // entries at or above the fill count are never read
    always_ff @(posedge clk)
    begin
        if (we)
            char_mem[total_reg[AW-1:0]] <= shift_reg[3:0];
        if (re)
            rd_reg <= char_mem[rp_reg[AW-1:0]];
    end

    assign character       = hit_reg ? rd_reg : 4'd0;
    assign character_valid = hit_reg;
    assign track_loaded    = loaded_reg;
    assign stored_count    = 6'(total_reg);

    `MSD_ASSERT(a_rp_le_total, rp_reg <= total_reg, "read pointer past fill count")
    `MSD_ASSERT(a_total_max, total_reg <= CW'(MAX_CHARS), "fill count beyond store depth")
    `MSD_ASSERT(a_loaded_nonempty, !loaded_reg || (total_reg != '0), "loaded with empty store")
    `MSD_ASSERT_NEXT(a_loaded_hold, loaded_reg && !cmd.exec, loaded_reg, "loaded flag dropped idle")

endmodule

[tb/sv/tb_mag_stripe_track_deframer.sv]
`timescale 1ns / 1ps

module tb_mag_stripe_track_deframer;
    import msd_pkg::*;

    localparam int MAX_CHARS = 40;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 300;

    typedef struct packed {
        logic [3:0] character;
        logic       character_valid;
        logic       track_loaded;
        logic [5:0] stored_count;
    } track_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    msd_in_if  in_ch ();
    msd_out_if out_ch ();

    mag_stripe_track_deframer #(
        .MAX_CHARS (MAX_CHARS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // deframer shadow state
    logic [4:0] start_pattern;
    logic [3:0] end_char;
    logic [4:0] frame_shift;
    logic       sentinel_seen;
    logic [2:0] bit_pos;
    logic [5:0] fill_count;
    logic [5:0] read_idx;
    logic       capture_frozen;
    logic [3:0] char_mem [MAX_CHARS];

    track_result_t expected_chars[$];

    int mismatch_count = 0;
    int counted_items = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    function automatic void clear_track();
        frame_shift = '0;
        sentinel_seen = 1'b0;
        bit_pos = '0;
        fill_count = '0;
        read_idx = '0;
        capture_frozen = 1'b0;
        foreach (char_mem[i])
            char_mem[i] = '0;
    endfunction

    function automatic void framing_edge(logic bitv);
        if (!sentinel_seen)
        begin
            // hunt: new bit enters at the top
            frame_shift = {bitv, frame_shift[4:1]};
            if (frame_shift == start_pattern)
            begin
                sentinel_seen = 1'b1;
                frame_shift = '0;
            end
        end
        else if (bit_pos < 3'd4)
        begin
            frame_shift = frame_shift | (5'(bitv) << bit_pos);
            bit_pos = bit_pos + 3'd1;
        end
        else
        begin
            // parity bit: store, drop once full
            if (fill_count < MAX_CHARS)
            begin
                char_mem[fill_count] = frame_shift[3:0];
                fill_count = fill_count + 6'd1;
            end
            frame_shift = '0;
            bit_pos = '0;
            if (fill_count != 6'd0 && char_mem[fill_count - 6'd1] == end_char)
                capture_frozen = 1'b1;
        end
    endfunction

    // returns 1 when the request has an effect beyond being ignored
    function automatic bit predict_track(logic [1:0] cmd, logic data, logic en);
        track_result_t r;
        bit active;
        r = '0;
        active = 1'b1;
        case (cmd)
            CMD_CLOCK:
                if (!en && !capture_frozen)
                    framing_edge(~data);
                else
                    active = 1'b0;
            CMD_READ:
                if (capture_frozen && read_idx < fill_count)
                begin
                    r.character = char_mem[read_idx];
                    r.character_valid = 1'b1;
                    read_idx = read_idx + 6'd1;
                end
                else
                    clear_track();
            CMD_RESET:
                clear_track();
            default:
                active = 1'b0;
        endcase
        r.track_loaded = capture_frozen;
        r.stored_count = fill_count;
        expected_chars.push_back(r);
        return active;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result();
        track_result_t want;
        if (expected_chars.size() == 0)
            report_mismatch("result with nothing expected", 32'(out_ch.character), 32'd0);
        else
        begin
            want = expected_chars.pop_front();
            if (out_ch.character !== want.character)
                report_mismatch("character", 32'(out_ch.character), 32'(want.character));
            if (out_ch.character_valid !== want.character_valid)
                report_mismatch("character_valid", 32'(out_ch.character_valid),
                                32'(want.character_valid));
            if (out_ch.track_loaded !== want.track_loaded)
                report_mismatch("track_loaded", 32'(out_ch.track_loaded),
                                32'(want.track_loaded));
            if (out_ch.stored_count !== want.stored_count)
                report_mismatch("stored_count", 32'(out_ch.stored_count),
                                32'(want.stored_count));
        end
    endtask

    // result side: check, then decide ready for the next edge
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            check_result();
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] cmd, logic data, logic en);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.command <= cmd;
        in_ch.data_line <= data;
        in_ch.enable_line <= en;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (predict_track(cmd, data, en))
            counted_items++;
    endtask

    // pin is active low: bit one drives data_line low
    task automatic card_edge(logic bitv);
        send_request(CMD_CLOCK, ~bitv, 1'b0);
    endtask

    task automatic send_noise(int pct);
        int sel;
        if ($urandom_range(99) < pct)
        begin
            sel = $urandom_range(19);
            if (sel < 8)
                send_request(CMD_CLOCK, 1'($urandom), 1'b1);
            else if (sel < 16)
                send_request(CMD_UNUSED, 1'($urandom), 1'($urandom));
            else if (sel < 18)
                send_request(CMD_READ, 1'($urandom), 1'($urandom));
            else
                send_request(CMD_RESET, 1'($urandom), 1'($urandom));
        end
    endtask

    task automatic send_char(logic [3:0] c, int noise_pct);
        logic [4:0] bits;
        bits = {~^c, c};
        if ($urandom_range(99) < 15)
            bits[4] = 1'($urandom);
        for (int i = 0; i < 5; i++)
        begin
            send_noise(noise_pct);
            card_edge(bits[i]);
        end
    endtask

    function automatic logic [3:0] pick_char(bit allow_end);
        logic [3:0] c;
        c = 4'($urandom);
        while (!allow_end && c == end_char)
            c = 4'($urandom);
        return c;
    endfunction

    // leading zeros, start sentinel, characters, then read out the track or reset it
    task automatic swipe(int nchars, bit end_last, int noise_pct, int early_end_pct);
        int lead;
        logic [3:0] c;
        lead = $urandom_range(6);
        for (int i = 0; i < lead && !sentinel_seen; i++)
            card_edge(1'b0);
        for (int i = 0; i < 5 && !sentinel_seen; i++)
            card_edge(start_pattern[i]);
        for (int i = 0; i < nchars; i++)
        begin
            if (end_last && i == nchars - 1)
                c = end_char;
            else
                c = pick_char($urandom_range(99) < early_end_pct);
            send_char(c, noise_pct);
        end
        if ($urandom_range(9) == 0)
            send_request(CMD_RESET, 1'($urandom), 1'($urandom));
        else
        begin
            while (capture_frozen && read_idx < fill_count)
                send_request(CMD_READ, 1'($urandom), 1'($urandom));
            // nothing left: this read clears the block
            send_request(CMD_READ, 1'($urandom), 1'($urandom));
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_reg(logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        value = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_sentinels(logic [4:0] start_val, logic [3:0] end_val);
        logic [APB_DW-1:0] rd;
        wait_drained();
        // upper bits are junk the register must drop
        write_reg(ADDR_START, ($urandom() & ~32'h1F) | APB_DW'(start_val));
        start_pattern = start_val;
        write_reg(ADDR_END, ($urandom() & ~32'hF) | APB_DW'(end_val));
        end_char = end_val;
        read_reg(ADDR_START, rd);
        if (rd !== APB_DW'(start_pattern))
            report_mismatch("start_sentinel readback", rd, 32'(start_pattern));
        read_reg(ADDR_END, rd);
        if (rd !== APB_DW'(end_char))
            report_mismatch("end_sentinel readback", rd, 32'(end_char));
    endtask

    task automatic test_directed();
        idle_pct = 0;
        stall_pct = 0;
        send_request(CMD_CLOCK, 1'b0, 1'b1);     // card absent
        send_request(CMD_UNUSED, 1'b1, 1'b0);
        send_request(CMD_READ, 1'b0, 1'b0);      // nothing loaded: clears
        card_edge(1'b0);
        for (int i = 0; i < 5; i++)
            card_edge(start_pattern[i]);
        send_char(4'd0, 0);
        send_char(4'd15, 0);                      // end sentinel at reset value
        card_edge(1'b1);                          // capture frozen
        send_request(CMD_READ, 1'b1, 1'b1);
        send_request(CMD_READ, 1'b0, 1'b1);
        send_request(CMD_READ, 1'b1, 1'b0);      // drained: clears
        send_request(CMD_RESET, 1'b1, 1'b1);
    endtask

    task automatic test_store_full();
        idle_pct = 0;
        stall_pct = 35;
        swipe(44, 1'b0, 0, 0);                    // overflow, never loaded
        swipe(40, 1'b1, 0, 0);                    // end sentinel lands in last slot
        swipe(42, 1'b1, 0, 0);                    // end sentinel dropped
    endtask

    task automatic test_config_sweep();
        logic [4:0] starts [4];
        logic [3:0] ends [4];
        starts = '{5'd0, 5'd31, 5'($urandom), START_SENTINEL_RST};
        ends = '{4'd0, 4'd15, 4'($urandom), END_SENTINEL_RST};
        idle_pct = 35;
        stall_pct = 35;
        for (int i = 0; i < 4; i++)
        begin
            set_sentinels(starts[i], ends[i]);
            swipe($urandom_range(1, 6), 1'b1, 5, 3);
            swipe($urandom_range(1, 6), 1'b1, 0, 0);
        end
    endtask

    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        hold_request = 80;
        swipe(12, 1'b1, 0, 0);
        // sender waits for every result before going on
        wait_drained();
    endtask

    task automatic test_random_swipes(int target);
        int roll;
        int start_items;
        start_items = counted_items;
        while (counted_items - start_items < target)
        begin
            case ((counted_items - start_items) * 4 / target)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 88;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 88;
                end
                default:
                begin
                    idle_pct = 35;
                    stall_pct = 35;
                end
            endcase
            roll = $urandom_range(99);
            if (roll < 6)
                set_sentinels(5'($urandom), 4'($urandom));
            else if (roll < 12)
                repeat ($urandom_range(1, 6))
                    send_request(2'($urandom), 1'($urandom), 1'($urandom));
            else
                swipe(($urandom_range(99) < 5) ? $urandom_range(36, 45) : $urandom_range(1, 12),
                      $urandom_range(99) < 85, $urandom_range(1) ? 0 : 10, 3);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_CLOCK;
        in_ch.data_line = 1'b1;
        in_ch.enable_line = 1'b1;
        out_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start_pattern = START_SENTINEL_RST;
        end_char = END_SENTINEL_RST;
        clear_track();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_store_full();
        test_config_sweep();
        test_backpressure();
        test_random_swipes(RANDOM_ITEMS);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
